[rtl/pse_pkg.sv]
`default_nettype none

package pse_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W = 3;
  localparam int STATUS_W = 2;
  localparam int STACK_DEPTH_DEF = 64;

  // Token kinds
  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
  localparam logic [OP_W-1:0] OP_POW  = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_POW
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_sts_t;

endpackage

`default_nettype wire

[rtl/pse_stack.sv]
`default_nettype none

module pse_stack #(
  parameter int DEPTH = pse_pkg::STACK_DEPTH_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [pse_pkg::DATA_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [AW-1:0]             raddr,
  output logic      [pse_pkg::DATA_W-1:0] rdata
);

  logic [pse_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/pse_alu.sv]
`default_nettype none

module pse_alu (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire pse_pkg::alu_ctl_t          ctl,
  input  wire logic [pse_pkg::DATA_W-1:0] a,
  input  wire logic [pse_pkg::DATA_W-1:0] b,
  output pse_pkg::alu_sts_t               sts,
  output logic      [pse_pkg::DATA_W-1:0] res
);

  localparam int W = pse_pkg::DATA_W;
  localparam int CW = $clog2(W);

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_FIX,
    A_POW,
    A_DONE
  } alu_state_t;

  alu_state_t     state;
  logic [W-1:0]   acc;      // product accumulator, multiplicand, quotient
  logic [W-1:0]   sq;       // running square, multiplier, divisor
  logic [W-1:0]   rem;
  logic [W-1:0]   expo;
  logic [CW-1:0]  cnt;
  logic           neg;
  logic           dz;
  logic           phase;

  logic           use_acc;
  logic [W-1:0]   mul_a;
  logic [W-1:0]   prod;
  logic [W:0]     rem_sh;
  logic [W:0]     diff;
  logic           ge;
  logic [W-1:0]   rem_next;
  logic [W-1:0]   quo_next;

  // One shared multiplier: acc * sq or sq * sq
  assign use_acc = (state == A_MUL) || ((state == A_POW) && expo[0] && !phase);
  assign mul_a = use_acc ? acc : sq;
  assign prod = mul_a * sq;

  // One restoring division step
  assign rem_sh = {rem, acc[W-1]};
  assign diff = rem_sh - {1'b0, sq};
  assign ge = !diff[W];
  assign rem_next = ge ? diff[W-1:0] : rem_sh[W-1:0];
  assign quo_next = {acc[W-2:0], ge};

  assign sts.done = (state == A_DONE);
  assign sts.div_zero = dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      dz <= 1'b0;
    end else begin
      case (state)
        A_IDLE: begin
          if (ctl.start) begin
            dz <= (ctl.op == pse_pkg::ALU_DIV) && (b == '0);
            case (ctl.op)
              pse_pkg::ALU_ADD: begin
                res <= a + b;
                state <= A_DONE;
              end
              pse_pkg::ALU_SUB: begin
                res <= a - b;
                state <= A_DONE;
              end
              pse_pkg::ALU_MUL: begin
                acc <= a;
                sq <= b;
                state <= A_MUL;
              end
              pse_pkg::ALU_DIV: begin
                if (b == '0) begin
                  state <= A_DONE;
                end else begin
                  acc <= a[W-1] ? -a : a;
                  sq <= b[W-1] ? -b : b;
                  rem <= '0;
                  cnt <= CW'(W - 1);
                  neg <= a[W-1] ^ b[W-1];
                  state <= A_DIV;
                end
              end
              pse_pkg::ALU_POW: begin
                if (b[W-1]) begin
                  // negative exponent: only bases of plus and minus one survive
                  if (a == W'(1)) begin
                    res <= W'(1);
                  end else if (a == '1) begin
                    res <= b[0] ? '1 : W'(1);
                  end else begin
                    res <= '0;
                  end
                  state <= A_DONE;
                end else begin
                  acc <= W'(1);
                  sq <= a;
                  expo <= b;
                  phase <= 1'b0;
                  state <= A_POW;
                end
              end
              default: begin
                res <= '0;
                state <= A_DONE;
              end
            endcase
          end
        end
        A_MUL: begin
          res <= prod;
          state <= A_DONE;
        end
        A_DIV: begin
          rem <= rem_next;
          acc <= quo_next;
          cnt <= cnt - CW'(1);
          if (cnt == '0) begin
            state <= A_FIX;
          end
        end
        A_FIX: begin
          res <= neg ? -acc : acc;
          state <= A_DONE;
        end
        A_POW: begin
          if (expo == '0) begin
            res <= acc;
            state <= A_DONE;
          end else if (expo[0] && !phase) begin
            acc <= prod;
            phase <= 1'b1;
          end else begin
            sq <= prod;
            expo <= expo >> 1;
            phase <= 1'b0;
          end
        end
        A_DONE: begin
          state <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == A_DIV && cnt == '0) |=> (state == A_FIX))
    else $error("division did not finish after its last step");

  assert property (@(posedge clk) disable iff (rst)
    (ctl.start && state == A_IDLE) |=> (state != A_IDLE))
    else $error("accepted start left the unit idle");

  assert property (@(posedge clk) disable iff (rst)
    (state == A_DIV) |-> (sq != '0))
    else $error("division running with zero divisor");

endmodule

`default_nettype wire

[rtl/postfix_stack_evaluator.sv]
`default_nettype none

// Channel   Direction  Handshake            Payload
// token     in         in_valid/in_ready    op, operand_value, end_of_expression
// result    out        out_valid/out_ready  result_value, status
//
// One token at a time; in_ready is low while a token is in work.
// Divide runs the bit-serial divider (32 steps); a zero divisor skips the steps.
// Power takes up to two shared-multiplier passes per exponent bit.
// A last token reads the top of a clean stack, then waits for a free result
// register; one result may wait while the next token is accepted.
// Synchronous reset empties the stack and clears the error; no clearing pass.
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic        [pse_pkg::OP_W-1:0]     op,
  input  wire logic signed [pse_pkg::DATA_W-1:0]   operand_value,
  input  wire logic                                end_of_expression,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed      [pse_pkg::DATA_W-1:0]   result_value,
  output logic             [pse_pkg::STATUS_W-1:0] status
);

  localparam int W = pse_pkg::DATA_W;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_R,
    S_RD_L,
    S_EXEC,
    S_FINISH,
    S_RD_TOP,
    S_EMIT
  } state_t;

  state_t                        state;
  logic [SPW-1:0]                sp;
  logic [pse_pkg::STATUS_W-1:0]  err;
  logic [pse_pkg::OP_W-1:0]      tok_op;
  logic [W-1:0]                  tok_value;
  logic                          tok_last;
  logic [W-1:0]                  r_opnd;
  logic [W-1:0]                  res_hold;
  logic [pse_pkg::STATUS_W-1:0]  st_hold;

  logic [SPW-1:0]                sp_m1;
  logic [SPW-1:0]                sp_m2;
  logic                          is_arith;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [W-1:0]                  mem_wdata;
  logic                          mem_re;
  logic [AW-1:0]                 mem_raddr;
  logic [W-1:0]                  mem_rdata;
  pse_pkg::alu_ctl_t             alu_ctl;
  pse_pkg::alu_sts_t             alu_sts;
  logic [W-1:0]                  alu_res;

  assign in_ready = (state == S_IDLE);
  assign sp_m1 = sp - SPW'(1);
  assign sp_m2 = sp - SPW'(2);
  assign is_arith = tok_op inside {[pse_pkg::OP_ADD : pse_pkg::OP_POW]};

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = sp[AW-1:0];
    mem_wdata = tok_value;
    mem_re = 1'b0;
    mem_raddr = sp_m1[AW-1:0];
    alu_ctl.start = 1'b0;
    case (tok_op)
      pse_pkg::OP_SUB: alu_ctl.op = pse_pkg::ALU_SUB;
      pse_pkg::OP_MUL: alu_ctl.op = pse_pkg::ALU_MUL;
      pse_pkg::OP_DIV: alu_ctl.op = pse_pkg::ALU_DIV;
      pse_pkg::OP_POW: alu_ctl.op = pse_pkg::ALU_POW;
      default:         alu_ctl.op = pse_pkg::ALU_ADD;
    endcase
    case (state)
      S_DECODE: begin
        if (err == pse_pkg::ST_OK) begin
          if (tok_op == pse_pkg::OP_PUSH) begin
            mem_we = (sp != SPW'(STACK_DEPTH));
          end else if (is_arith && sp >= SPW'(2)) begin
            mem_re = 1'b1;
          end
        end
      end
      S_RD_R: begin
        mem_re = 1'b1;
        mem_raddr = sp_m2[AW-1:0];
      end
      S_RD_L: begin
        alu_ctl.start = 1'b1;
      end
      S_EXEC: begin
        mem_we = alu_sts.done && !alu_sts.div_zero;
        mem_waddr = sp_m2[AW-1:0];
        mem_wdata = alu_res;
      end
      S_FINISH: begin
        mem_re = tok_last && (err == pse_pkg::ST_OK) && (sp != '0);
      end
      default: begin
      end
    endcase
  end

  pse_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pse_alu u_alu (
    .clk (clk),
    .rst (rst),
    .ctl (alu_ctl),
    .a   (mem_rdata),
    .b   (r_opnd),
    .sts (alu_sts),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp <= '0;
      err <= pse_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      // the emit state reloads the result register itself
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            tok_op <= op;
            tok_value <= operand_value;
            tok_last <= end_of_expression;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (err != pse_pkg::ST_OK) begin
            // first error sticks; skip the token
            state <= S_FINISH;
          end else if (tok_op == pse_pkg::OP_PUSH) begin
            if (sp == SPW'(STACK_DEPTH)) begin
              err <= pse_pkg::ST_OVER;
            end else begin
              sp <= sp + SPW'(1);
            end
            state <= S_FINISH;
          end else if (is_arith) begin
            if (sp < SPW'(2)) begin
              err <= pse_pkg::ST_UNDER;
              state <= S_FINISH;
            end else begin
              state <= S_RD_R;
            end
          end else begin
            state <= S_FINISH;
          end
        end
        S_RD_R: begin
          r_opnd <= mem_rdata;
          state <= S_RD_L;
        end
        S_RD_L: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (alu_sts.done) begin
            if (alu_sts.div_zero) begin
              err <= pse_pkg::ST_DIVZ;
            end else begin
              sp <= sp_m1;
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!tok_last) begin
            state <= S_IDLE;
          end else if (err != pse_pkg::ST_OK) begin
            res_hold <= '0;
            st_hold <= err;
            state <= S_EMIT;
          end else if (sp == '0) begin
            res_hold <= '0;
            st_hold <= pse_pkg::ST_UNDER;
            state <= S_EMIT;
          end else begin
            state <= S_RD_TOP;
          end
        end
        S_RD_TOP: begin
          res_hold <= mem_rdata;
          st_hold <= pse_pkg::ST_OK;
          state <= S_EMIT;
        end
        S_EMIT: begin
          // hold until the result register is free
          if (!out_valid || out_ready) begin
            result_value <= res_hold;
            status <= st_hold;
            out_valid <= 1'b1;
            sp <= '0;
            err <= pse_pkg::ST_OK;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && (!out_valid || out_ready))
      |=> (out_valid && sp == '0 && err == pse_pkg::ST_OK))
    else $error("expression end did not emit and clear");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != pse_pkg::ST_OK) |-> (result_value == '0))
    else $error("nonzero result with error status");

  assert property (@(posedge clk) disable iff (rst)
    alu_sts.done |-> (state == S_EXEC))
    else $error("arithmetic unit finished outside execute");

endmodule

`default_nettype wire
